### sv/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg
// Types and constants shared by the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

    localparam int MAX_TASKS  = 8;
    localparam int IDX_W      = 3;   // task_index field
    localparam int CNT_W      = 4;   // task_count register and running_task
    localparam int TIME_W     = 10;  // exec_time, task_period, budget, countdown

    localparam logic [CNT_W-1:0] TASK_COUNT_RST = 4'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // one task table entry as seen on the read port
    typedef struct packed {
        logic [TIME_W-1:0] exec_time;
        logic [TIME_W-1:0] task_period;
        logic [TIME_W-1:0] budget;
        logic [TIME_W-1:0] countdown;
    } entry_t;

    // write request into the task table
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              load;       // write exec/period and reset budget/countdown
        logic [TIME_W-1:0] exec_time;
        logic [TIME_W-1:0] task_period;
        logic              budget_we;
        logic [TIME_W-1:0] budget;
        logic              cd_we;
        logic [TIME_W-1:0] countdown;
    } tbl_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

### sv/rmts_task_table.sv
// ----------------------------------------------------------------------------
// rmts_task_table
// Per-task storage: exec time, period, remaining budget and period countdown.
// One combinational read port, one write port.
// ----------------------------------------------------------------------------
module rmts_task_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rmts_pkg::IDX_W-1:0]  rd_idx,
    output rmts_pkg::entry_t            rd_entry,
    input  rmts_pkg::tbl_wr_t           wr
);
    import rmts_pkg::*;

    logic [TIME_W-1:0] exec_tbl_reg   [MAX_TASKS];
    logic [TIME_W-1:0] period_tbl_reg [MAX_TASKS];
    logic [TIME_W-1:0] budget_reg     [MAX_TASKS];
    logic [TIME_W-1:0] countdown_reg  [MAX_TASKS];

    // exec/period hold garbage until loaded
    always_ff @(posedge clk)
    begin
        if (wr.load)
        begin
            exec_tbl_reg[wr.idx]   <= wr.exec_time;
            period_tbl_reg[wr.idx] <= wr.task_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                budget_reg[i]    <= '0;
                countdown_reg[i] <= '0;
            end
        end
        else if (wr.load)
        begin
            budget_reg[wr.idx]    <= wr.exec_time;
            countdown_reg[wr.idx] <= wr.task_period;
        end
        else
        begin
            if (wr.budget_we)
                budget_reg[wr.idx] <= wr.budget;
            if (wr.cd_we)
                countdown_reg[wr.idx] <= wr.countdown;
        end
    end

    assign rd_entry.exec_time   = exec_tbl_reg[rd_idx];
    assign rd_entry.task_period = period_tbl_reg[rd_idx];
    assign rd_entry.budget      = budget_reg[rd_idx];
    assign rd_entry.countdown   = countdown_reg[rd_idx];

endmodule

### sv/rmts_sequencer.sv
// ----------------------------------------------------------------------------
// rmts_sequencer
// Walks the active entries one per cycle through a shared compare/decrement
// unit, tracks the shortest-period candidate and steps the countdowns.
// ----------------------------------------------------------------------------
module rmts_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [rmts_pkg::IDX_W-1:0]   task_index,
    input  logic [rmts_pkg::TIME_W-1:0]  exec_time,
    input  logic [rmts_pkg::TIME_W-1:0]  task_period,
    output logic                         done,
    output logic [rmts_pkg::CNT_W-1:0]   running_task,
    input  logic                         cfg_we,
    input  logic [rmts_pkg::CNT_W-1:0]   cfg_data,
    output logic [rmts_pkg::IDX_W-1:0]   rd_idx,
    input  rmts_pkg::entry_t             rd_entry,
    output rmts_pkg::tbl_wr_t            wr
);
    import rmts_pkg::*;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   best_reg, best_next;
    logic [TIME_W-1:0]  best_period_reg, best_period_next;
    logic               found_reg, found_next;
    logic               best_reload_reg, best_reload_next;
    logic [CNT_W-1:0]   task_count_reg;

    logic [CNT_W-1:0]   n_active;
    logic               last_entry;
    logic               pick;
    logic               reload;
    logic [TIME_W-1:0]  dec_in;
    logic [TIME_W-1:0]  dec_out;

    assign n_active   = (task_count_reg > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                               : task_count_reg;
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_active);

    // shared unit: priority compare, and one decrementer that steps the
    // countdown during the scan and spends the chosen budget at the end
    assign pick    = (rd_entry.budget != '0) &&
                     (!found_reg || (rd_entry.task_period < best_period_reg));
    assign dec_in  = (state_reg == ST_DONE) ? rd_entry.budget : rd_entry.countdown;
    assign dec_out = dec_in - TIME_W'(1);
    assign reload  = (rd_entry.countdown != '0) && (dec_out == '0);

    assign rd_idx = (state_reg == ST_DONE) ? best_reg : idx_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        best_next        = best_reg;
        best_period_next = best_period_reg;
        found_next       = found_reg;
        best_reload_next = best_reload_reg;

        wr             = '0;
        wr.idx         = rd_idx;
        wr.exec_time   = exec_time;
        wr.task_period = task_period;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_LOAD)
                    begin
                        wr.idx  = task_index;
                        wr.load = 1'b1;
                    end
                    else
                    begin
                        idx_next         = '0;
                        found_next       = 1'b0;
                        best_reload_next = 1'b0;
                        state_next       = (n_active == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pick)
                begin
                    best_next        = idx_reg;
                    best_period_next = rd_entry.task_period;
                    found_next       = 1'b1;
                    best_reload_next = reload;
                end
                if (rd_entry.countdown != '0)
                begin
                    wr.cd_we = 1'b1;
                    if (reload)
                    begin
                        wr.countdown = rd_entry.task_period;
                        wr.budget_we = 1'b1;
                        wr.budget    = rd_entry.exec_time;
                    end
                    else
                        wr.countdown = dec_out;
                end
                if (last_entry)
                    state_next = ST_DONE;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_DONE:
            begin
                // a reload of the chosen task overrides its spent tick
                if (found_reg && !best_reload_reg)
                begin
                    wr.budget_we = 1'b1;
                    wr.budget    = dec_out;
                end
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            best_reg        <= '0;
            found_reg       <= 1'b0;
            best_reload_reg <= 1'b0;
            task_count_reg  <= TASK_COUNT_RST;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            best_reg        <= best_next;
            found_reg       <= found_next;
            best_reload_reg <= best_reload_next;
            if (cfg_we)
                task_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        best_period_reg <= best_period_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign running_task = found_reg ? (CNT_W'(best_reg) + CNT_W'(1)) : '0;

endmodule

### sv/rate_monotonic_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler_core
// Rate-monotonic scheduler: task table plus a sequencer that picks the
// shortest-period task with budget each tick and steps the period countdowns.
//
//   channel  | handshake              | word
//   ---------+------------------------+-----------------------------------------
//   command  | start & !busy          | command, task_index, exec_time, task_period
//   result   | done (one-cycle pulse) | running_task
//   config   | cfg_we                 | cfg_data (task_count)
//
// A load writes the table straight from idle; busy stays low.
// A tick steps through the n = min(task_count, 8) active entries in the shared
// compare/decrement unit, then updates the chosen budget in the done state.
// done pulses in the done state; the receiver cannot stall it.
// Reset clears all budgets and countdowns; task_count resets to 3.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [rmts_pkg::IDX_W-1:0]   task_index,
    input  logic [rmts_pkg::TIME_W-1:0]  exec_time,
    input  logic [rmts_pkg::TIME_W-1:0]  task_period,
    output logic                         done,
    output logic [rmts_pkg::CNT_W-1:0]   running_task,
    input  logic                         cfg_we,
    input  logic [rmts_pkg::CNT_W-1:0]   cfg_data
);
    import rmts_pkg::*;

    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_entry;
    tbl_wr_t          wr;

    rmts_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .task_index   (task_index),
        .exec_time    (exec_time),
        .task_period  (task_period),
        .done         (done),
        .running_task (running_task),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .rd_idx       (rd_idx),
        .rd_entry     (rd_entry),
        .wr           (wr)
    );

    rmts_task_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

endmodule

### sv/rmts_checker.sv
// ----------------------------------------------------------------------------
// rmts_checker
// Port-level checks on the scheduler core, attached by bind.
// ----------------------------------------------------------------------------
module rmts_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         command,
    input  logic                         done,
    input  logic [rmts_pkg::CNT_W-1:0]   running_task
);
    import rmts_pkg::*;

    // a tick always runs through the sequencer
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_TICK)) |=> busy)
        else $error("tick accepted but block not busy");

    // a load finishes in its own cycle and gives no word
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_LOAD)) |=> (!busy && !done))
        else $error("load left block busy or gave a word");

    // the result word marks the final busy cycle
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside busy");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("busy or done after done");

    a_task_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (running_task <= CNT_W'(MAX_TASKS)))
        else $error("running_task out of range");

endmodule

bind rate_monotonic_tick_scheduler_core rmts_checker u_rmts_checker (.*);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rate_monotonic_tick_scheduler_core. A stimulus table
// covers the corner cases, then randomized load/tick words run over several
// task_count settings and sender idle rates. Every tick is checked against
// running_task as predicted by a behavioral model of the task table or given in its table row.
// ----------------------------------------------------------------------------
module tb;
    import rmts_pkg::*;

    localparam int SETTLE_CYCLES   = 12;    // covers the longest tick
    localparam int DRAIN_LIMIT     = 2000;
    localparam int N_PHASES        = 6;
    localparam int WORDS_PER_PHASE = 190;
    localparam int N_ROWS          = 24;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic              command     = CMD_LOAD;
    logic [IDX_W-1:0]  task_index  = '0;
    logic [TIME_W-1:0] exec_time   = '0;
    logic [TIME_W-1:0] task_period = '0;
    logic              done;
    logic [CNT_W-1:0]  running_task;
    logic              cfg_we      = 1'b0;
    logic [CNT_W-1:0]  cfg_data    = '0;

    rate_monotonic_tick_scheduler_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .task_index   (task_index),
        .exec_time    (exec_time),
        .task_period  (task_period),
        .done         (done),
        .running_task (running_task),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // scheduler state as the block should hold it
    logic [TIME_W-1:0] sched_exec      [MAX_TASKS];
    logic [TIME_W-1:0] sched_period    [MAX_TASKS];
    logic [TIME_W-1:0] sched_budget    [MAX_TASKS];
    logic [TIME_W-1:0] sched_countdown [MAX_TASKS];
    logic [CNT_W-1:0]  sched_task_count;

    logic [CNT_W-1:0]  exp_running [$];
    int                n_fail = 0;

    // one tick: pick shortest period with budget, spend it, then step countdowns
    function automatic logic [CNT_W-1:0] schedule_tick();
        int               n;
        int               best;
        int               i;
        logic [CNT_W-1:0] run;
        n    = (sched_task_count > MAX_TASKS) ? MAX_TASKS : int'(sched_task_count);
        best = -1;
        run  = '0;
        for (i = 0; i < n; i++)
        begin
            if (sched_budget[i] != '0)
            begin
                if (best < 0)
                    best = i;
                else if (sched_period[i] < sched_period[best])
                    best = i;
            end
        end
        if (best >= 0)
        begin
            sched_budget[best] = sched_budget[best] - 1'b1;
            run = CNT_W'(best + 1);
        end
        // a zero countdown marks a one-shot task: it never steps or reloads
        for (i = 0; i < n; i++)
        begin
            if (sched_countdown[i] != '0)
            begin
                sched_countdown[i] = sched_countdown[i] - 1'b1;
                if (sched_countdown[i] == '0)
                begin
                    sched_budget[i]    = sched_exec[i];
                    sched_countdown[i] = sched_period[i];
                end
            end
        end
        return run;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (exp_running.size() == 0)
            begin
                $error("running_task: no word expected, got %0d", running_task);
                n_fail++;
            end
            else
            begin
                if (running_task !== exp_running[0])
                begin
                    $error("running_task: expected %0d, got %0d", exp_running[0],
                           running_task);
                    n_fail++;
                end
                void'(exp_running.pop_front());
            end
        end
    end

    // drive one word, hold until accepted, then update the model
    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [TIME_W-1:0] et, input logic [TIME_W-1:0] per,
                             input int idle_pct, input logic typed,
                             input logic [CNT_W-1:0] typed_run);
        logic [CNT_W-1:0] run;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        task_index  <= idx;
        exec_time   <= et;
        task_period <= per;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == CMD_TICK)
        begin
            run = schedule_tick();
            exp_running.push_back(typed ? typed_run : run);
        end
        else
        begin
            sched_exec[idx]      = et;
            sched_period[idx]    = per;
            sched_budget[idx]    = et;
            sched_countdown[idx] = per;
        end
    endtask

    // stop sending until every tick has reported and the block has settled
    task automatic wait_idle();
        int k;
        start <= 1'b0;
        k = 0;
        while (exp_running.size() != 0 && k < DRAIN_LIMIT)
        begin
            @(posedge clk);
            k++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_task_count(input logic [CNT_W-1:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sched_task_count = v;
    endtask

    task automatic random_word(input int idle_pct);
        logic [TIME_W-1:0] et;
        logic [TIME_W-1:0] per;
        int                r;
        if ($urandom_range(99) < 25)
        begin
            r = $urandom_range(99);
            if (r < 65)
                et = TIME_W'($urandom_range(1, 6));
            else if (r < 75)
                et = '0;
            else
                et = TIME_W'($urandom_range(1023));
            // short periods keep budgets reloading
            r = $urandom_range(99);
            if (r < 65)
                per = TIME_W'($urandom_range(1, 12));
            else if (r < 75)
                per = '0;
            else
                per = TIME_W'($urandom_range(1023));
            send_word(CMD_LOAD, IDX_W'($urandom_range(MAX_TASKS - 1)), et, per,
                      idle_pct, 1'b0, '0);
        end
        else
        begin
            // unused fields of a tick carry noise
            send_word(CMD_TICK, IDX_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                      idle_pct, 1'b0, '0);
        end
    endtask

    typedef struct packed {
        logic              set_count;   // row writes task_count instead of a word
        logic [CNT_W-1:0]  count;
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] exec_t;
        logic [TIME_W-1:0] period;
        logic              typed;       // running_task given in the row
        logic [CNT_W-1:0]  run;
    } step_row_t;

    step_row_t dir_rows [N_ROWS] = '{
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd0}, // idle after reset
        '{1'b1,  4'd0, CMD_LOAD, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_LOAD, 3'd0,    10'd2,    10'd0, 1'b0, 4'd0}, // one-shot task
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd0}, // no task active
        '{1'b1, 4'd15, CMD_LOAD, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0}, // clamps to 8
        '{1'b0,  4'd0, CMD_LOAD, 3'd7, 10'd1023, 10'd1023, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_LOAD, 3'd3,    10'd0,    10'd5, 1'b0, 4'd0}, // zero budget
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd1},
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd1},
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd8},
        '{1'b0,  4'd0, CMD_LOAD, 3'd1,    10'd1,    10'd1, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd2},
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd2},
        '{1'b1,  4'd1, CMD_LOAD, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b1, 4'd0}, // others inactive
        '{1'b1,  4'd8, CMD_LOAD, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_LOAD, 3'd1,    10'd0,    10'd0, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_LOAD, 3'd5,    10'd1,    10'd7, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_LOAD, 3'd6,    10'd1,    10'd7, 1'b0, 4'd0}, // equal periods
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_TICK, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0},
        '{1'b0,  4'd0, CMD_TICK, 3'd7, 10'd1023, 10'd1023, 1'b0, 4'd0},
        '{1'b1,  4'd3, CMD_LOAD, 3'd0,    10'd0,    10'd0, 1'b0, 4'd0}
    };

    int               idle_by_phase  [N_PHASES] = '{0, 52, 23, 0, 52, 23};
    logic [CNT_W-1:0] count_by_phase [N_PHASES] = '{4'd8, 4'd1, 4'd5, 4'd15, 4'd2, 4'd7};

    initial
    begin
        step_row_t row;
        int        r;
        int        ph;
        int        w;
        for (r = 0; r < MAX_TASKS; r++)
        begin
            sched_exec[r]      = '0;
            sched_period[r]    = '0;
            sched_budget[r]    = '0;
            sched_countdown[r] = '0;
        end
        sched_task_count = TASK_COUNT_RST;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_ROWS; r++)
        begin
            row = dir_rows[r];
            if (row.set_count)
                write_task_count(row.count);
            else
                send_word(row.cmd, row.idx, row.exec_t, row.period, 0, row.typed, row.run);
        end

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            write_task_count(count_by_phase[ph]);
            for (w = 0; w < WORDS_PER_PHASE; w++)
            begin
                if (ph == 2 && w == WORDS_PER_PHASE / 2)
                    wait_idle();
                random_word(idle_by_phase[ph]);
            end
        end

        wait_idle();
        if (exp_running.size() != 0)
        begin
            $error("running_task: %0d expected words never arrived", exp_running.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
